FILE: hdl/mte_pkg.sv
// ----------------------------------------------------------------------------
// Markup tag span extractor package
// Shared types, character codes, result kinds and defaults.
// ----------------------------------------------------------------------------
package mte_pkg;

	localparam int STACK_DEPTH_DEF   = 32;
	localparam int NAME_BYTES_DEF    = 8;
	localparam int POSITION_BITS_DEF = 16;

	localparam int IDX_MAX_W  = 11;
	localparam int POS_MAX_W  = 32;
	localparam int NAME_MAX_W = 64;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_OPEN  = 8'h3C;
	localparam logic [7:0] CH_CLOSE = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [2:0] {
		KIND_TEXT      = 3'd0,
		KIND_CLOSED    = 3'd1,
		KIND_END       = 3'd2,
		KIND_UNMATCHED = 3'd3,
		KIND_OVERFLOW  = 3'd4
	} kind_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] char_byte;
	} in_item_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [7:0]  text_byte;
		logic [63:0] tag_name;
		logic [3:0]  tag_name_length;
		logic        name_truncated;
		logic [15:0] span_start;
		logic [15:0] span_end;
	} out_item_t;

	typedef struct packed {
		logic                  push;
		logic                  name_wr;
		logic                  pop;
		logic                  emit;
		kind_t                 kind;
		logic [7:0]            text_byte;
		logic [IDX_MAX_W-1:0]  idx;
		logic [POS_MAX_W-1:0]  pos;
		logic [NAME_MAX_W-1:0] name;
		logic [3:0]            len;
		logic                  trunc;
	} cmd_t;

endpackage

FILE: hdl/mte_front.sv
// ----------------------------------------------------------------------------
// Markup tag span extractor front end
// Accepts items, tracks tag state and text position, issues stack and emit commands.
// ----------------------------------------------------------------------------
module mte_front #(
	parameter int STACK_DEPTH   = mte_pkg::STACK_DEPTH_DEF,
	parameter int NAME_BYTES    = mte_pkg::NAME_BYTES_DEF,
	parameter int POSITION_BITS = mte_pkg::POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  mte_pkg::in_item_t item,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output mte_pkg::cmd_t     cmd
);
	import mte_pkg::*;

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int NC_W   = $clog2(NAME_BYTES + 1);
	localparam int NAME_W = 8 * NAME_BYTES;

	logic                     inside_q, pending_q, novf_q;
	logic [NAME_W-1:0]        name_q;
	logic [NC_W-1:0]          ncount_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [CNT_W-1:0]         count_q;

	logic                     inside_d, pending_d, novf_d;
	logic [NAME_W-1:0]        name_d;
	logic [NC_W-1:0]          ncount_d;
	logic [POSITION_BITS-1:0] pos_d;
	logic [CNT_W-1:0]         count_d;
	cmd_t                     cmd_d;
	logic                     accept;

	assign item_ready = cmd_ready;
	assign accept     = item_valid & item_ready;
	assign cmd        = cmd_d;
	assign cmd_valid  = accept & (cmd_d.push | cmd_d.name_wr | cmd_d.pop | cmd_d.emit);

	always_comb begin
		logic [7:0] c;
		c         = item.char_byte;
		inside_d  = inside_q;
		pending_d = pending_q;
		novf_d    = novf_q;
		name_d    = name_q;
		ncount_d  = ncount_q;
		pos_d     = pos_q;
		count_d   = count_q;
		cmd_d     = '0;
		cmd_d.kind = KIND_TEXT;
		if (item.operation) begin
			cmd_d.emit = 1'b1;
			cmd_d.kind = KIND_END;
			cmd_d.pos  = POS_MAX_W'(pos_q);
			inside_d   = 1'b0;
			pending_d  = 1'b0;
			novf_d     = 1'b0;
			name_d     = '0;
			ncount_d   = '0;
			pos_d      = '0;
			count_d    = '0;
		end else begin
			if (pending_q) begin
				pending_d = 1'b0;
				if (c != CH_SLASH) begin
					if (count_d < CNT_W'(STACK_DEPTH)) begin
						cmd_d.push = 1'b1;
						cmd_d.idx  = IDX_MAX_W'(count_d);
						cmd_d.pos  = POS_MAX_W'(pos_q);
						count_d    = count_d + 1'b1;
					end else begin
						cmd_d.emit = 1'b1;
						cmd_d.kind = KIND_OVERFLOW;
					end
				end
			end
			if (c == CH_OPEN) begin
				inside_d  = 1'b1;
				pending_d = 1'b1;
				name_d    = '0;
				ncount_d  = '0;
				novf_d    = 1'b0;
			end else if (c == CH_CLOSE) begin
				if (inside_q) begin
					inside_d = 1'b0;
					if (ncount_q != '0 && name_q[7:0] == CH_SLASH) begin
						if (count_d == '0) begin
							cmd_d.emit = 1'b1;
							cmd_d.kind = KIND_UNMATCHED;
						end else begin
							count_d   = count_d - 1'b1;
							cmd_d.pop = 1'b1;
							cmd_d.idx = IDX_MAX_W'(count_d);
							cmd_d.pos = POS_MAX_W'(pos_q);
						end
					end else if (count_d != '0) begin
						cmd_d.name_wr = 1'b1;
						cmd_d.idx     = IDX_MAX_W'(count_d - 1'b1);
						cmd_d.name    = NAME_MAX_W'(name_q);
						cmd_d.len     = 4'(ncount_q);
						cmd_d.trunc   = novf_q;
					end
				end
			end else if (inside_q) begin
				if (ncount_q < NC_W'(NAME_BYTES)) begin
					for (int i = 0; i < NAME_BYTES; i++) begin
						if (ncount_q == NC_W'(i)) begin
							name_d[8*i +: 8] = c;
						end
					end
					ncount_d = ncount_q + 1'b1;
				end else begin
					novf_d = 1'b1;
				end
			end else begin
				cmd_d.emit      = 1'b1;
				cmd_d.kind      = KIND_TEXT;
				cmd_d.text_byte = c;
				if (pos_q != '1) begin
					pos_d = pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q  <= 1'b0;
			pending_q <= 1'b0;
			novf_q    <= 1'b0;
			name_q    <= '0;
			ncount_q  <= '0;
			pos_q     <= '0;
			count_q   <= '0;
		end else if (accept) begin
			inside_q  <= inside_d;
			pending_q <= pending_d;
			novf_q    <= novf_d;
			name_q    <= name_d;
			ncount_q  <= ncount_d;
			pos_q     <= pos_d;
			count_q   <= count_d;
		end
	end

endmodule

FILE: hdl/mte_queue.sv
// ----------------------------------------------------------------------------
// Markup tag span extractor command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mte_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  mte_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output mte_pkg::cmd_t pop_data
);
	import mte_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/mte_back.sv
// ----------------------------------------------------------------------------
// Markup tag span extractor back end
// Holds the tag stack memories and forms the result transactions.
// ----------------------------------------------------------------------------
module mte_back #(
	parameter int STACK_DEPTH   = mte_pkg::STACK_DEPTH_DEF,
	parameter int NAME_BYTES    = mte_pkg::NAME_BYTES_DEF,
	parameter int POSITION_BITS = mte_pkg::POSITION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  mte_pkg::cmd_t      cmd,
	output logic               result_valid,
	input  logic               result_ready,
	output mte_pkg::out_item_t result
);
	import mte_pkg::*;

	localparam int IDX_W  = $clog2(STACK_DEPTH);
	localparam int NAME_W = 8 * NAME_BYTES;
	localparam int NM_W   = NAME_W + 5;

	logic [POSITION_BITS-1:0] start_mem [STACK_DEPTH];
	logic [NM_W-1:0]          nm_mem    [STACK_DEPTH];

	logic [POSITION_BITS-1:0] start_s1;
	logic [NM_W-1:0]          nm_s1;
	cmd_t                     cmd_s1;
	logic                     valid_s1;
	logic                     out_valid_q;
	out_item_t                out_q, out_d;
	logic                     out_free, take, load;
	logic [IDX_W-1:0]         idx;
	logic [NM_W-1:0]          nm_wdata;
	logic [POS_MAX_W-1:0]     start_wide;

	assign out_free  = !out_valid_q || result_ready;
	assign cmd_ready = !valid_s1 || out_free;
	assign take      = cmd_valid & cmd_ready;
	assign load      = valid_s1 & out_free;
	assign idx       = cmd.idx[IDX_W-1:0];
	assign nm_wdata  = cmd.name_wr ? {cmd.trunc, cmd.len, cmd.name[NAME_W-1:0]} : '0;

	always_ff @(posedge clk) begin
		if (take) begin
			if (cmd.push) begin
				start_mem[idx] <= cmd.pos[POSITION_BITS-1:0];
			end
			if (cmd.push || cmd.name_wr) begin
				nm_mem[idx] <= nm_wdata;
			end
			start_s1 <= start_mem[idx];
			nm_s1    <= nm_mem[idx];
			cmd_s1   <= cmd;
		end
	end

	always_comb begin
		start_wide = POS_MAX_W'(start_s1);
		out_d      = '0;
		out_d.result_kind = cmd_s1.kind;
		if (cmd_s1.pop) begin
			out_d.result_kind     = KIND_CLOSED;
			out_d.tag_name        = NAME_MAX_W'(nm_s1[NAME_W-1:0]);
			out_d.tag_name_length = nm_s1[NAME_W +: 4];
			out_d.name_truncated  = nm_s1[NM_W-1];
			out_d.span_start      = start_wide[15:0];
			out_d.span_end        = cmd_s1.pos[15:0];
		end else begin
			out_d.text_byte = cmd_s1.text_byte;
			out_d.span_end  = cmd_s1.pos[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= cmd.pop | cmd.emit;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

FILE: hdl/markup_tag_span_extractor_top.sv
// ----------------------------------------------------------------------------
// Markup tag span extractor
// Strips tags from a markup byte stream and reports closed tag spans.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (item_valid, item_ready, item) carries one document byte
// or an end-of-document mark per transaction. The output channel
// (result_valid, result_ready, result) carries at most one result per input
// transaction, in input order: text bytes, closed tags with their spans,
// document end, unmatched closes and stack overflows.
// One input transaction is accepted per cycle while the command queue has room.
// A result passes through the four-entry command queue, the stack memory
// read register and the output register.
// The rate is set by the single port pair of the stack memories, which
// serves one push, name write or pop per cycle.
// At reset the tag stack is empty and the text position is zero; no memory
// clearing is needed. When the receiver stalls, the output register and the
// command queue fill and item_ready falls once the queue is full.
// ----------------------------------------------------------------------------
module markup_tag_span_extractor_top #(
	parameter int STACK_DEPTH   = mte_pkg::STACK_DEPTH_DEF,
	parameter int NAME_BYTES    = mte_pkg::NAME_BYTES_DEF,
	parameter int POSITION_BITS = mte_pkg::POSITION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  mte_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output mte_pkg::out_item_t result
);
	import mte_pkg::*;

	logic fq_valid, fq_ready, qb_valid, qb_ready;
	cmd_t fq_cmd, qb_cmd;

	mte_front #(
		.STACK_DEPTH(STACK_DEPTH),
		.NAME_BYTES(NAME_BYTES),
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.cmd_valid(fq_valid),
		.cmd_ready(fq_ready),
		.cmd(fq_cmd)
	);

	mte_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data(fq_cmd),
		.pop_valid(qb_valid),
		.pop_ready(qb_ready),
		.pop_data(qb_cmd)
	);

	mte_back #(
		.STACK_DEPTH(STACK_DEPTH),
		.NAME_BYTES(NAME_BYTES),
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(qb_valid),
		.cmd_ready(qb_ready),
		.cmd(qb_cmd),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

`ifndef ASSERT_OFF
	a_cmd_never_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		fq_valid |-> fq_ready)
		else $error("command issued while the queue is full");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.result_kind == KIND_TEXT ||
			result.result_kind == KIND_CLOSED || result.result_kind == KIND_END ||
			result.result_kind == KIND_UNMATCHED || result.result_kind == KIND_OVERFLOW))
		else $error("result kind out of range");

	a_text_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.result_kind == KIND_TEXT) |->
			(result.tag_name == '0 && result.span_start == '0 && result.span_end == '0))
		else $error("text result carries tag fields");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markup tag span extractor testbench
// Drives byte and end-of-document transactions with random gaps, predicts
// every result from a local model of the tag stack and compares each result
// field by field in order.
// ----------------------------------------------------------------------------
import mte_pkg::*;

class span_scoreboard;
	logic [15:0] starts [32];
	logic [63:0] names [32];
	logic [3:0] lens [32];
	logic truncs [32];
	int depth;
	bit in_tag;
	bit open_pend;
	logic [63:0] name_buf;
	int name_cnt;
	bit name_ovf;
	logic [15:0] text_pos;
	out_item_t expected_results [$];
	int errors;

	function void clear_state();
		depth = 0;
		in_tag = 0;
		open_pend = 0;
		name_buf = '0;
		name_cnt = 0;
		name_ovf = 0;
		text_pos = '0;
	endfunction

	function out_item_t blank(kind_t k);
		out_item_t r;
		r = '0;
		r.result_kind = k;
		return r;
	endfunction

	function void note_input(in_item_t it);
		out_item_t r;
		bit have;
		logic [7:0] c;
		have = 0;
		c = it.char_byte;
		r = '0;
		if (it.operation) begin
			r = blank(KIND_END);
			r.span_end = text_pos;
			clear_state();
			expected_results.push_back(r);
			return;
		end
		if (open_pend) begin
			open_pend = 0;
			if (c != CH_SLASH) begin
				if (depth < 32) begin
					starts[depth] = text_pos;
					names[depth] = '0;
					lens[depth] = '0;
					truncs[depth] = 0;
					depth++;
				end else begin
					r = blank(KIND_OVERFLOW);
					have = 1;
				end
			end
		end
		if (c == CH_OPEN) begin
			in_tag = 1;
			open_pend = 1;
			name_buf = '0;
			name_cnt = 0;
			name_ovf = 0;
		end else if (c == CH_CLOSE) begin
			if (in_tag) begin
				in_tag = 0;
				if (name_cnt > 0 && name_buf[7:0] == CH_SLASH) begin
					if (depth == 0) begin
						r = blank(KIND_UNMATCHED);
					end else begin
						depth--;
						r = blank(KIND_CLOSED);
						r.tag_name = names[depth];
						r.tag_name_length = lens[depth];
						r.name_truncated = truncs[depth];
						r.span_start = starts[depth];
						r.span_end = text_pos;
					end
					have = 1;
				end else if (depth > 0) begin
					names[depth-1] = name_buf;
					lens[depth-1] = 4'(name_cnt);
					truncs[depth-1] = name_ovf;
				end
			end
		end else if (in_tag) begin
			if (name_cnt < 8) begin
				name_buf[8*name_cnt +: 8] = c;
				name_cnt++;
			end else begin
				name_ovf = 1;
			end
		end else begin
			r = blank(KIND_TEXT);
			r.text_byte = c;
			have = 1;
			if (text_pos != 16'hFFFF)
				text_pos++;
		end
		if (have)
			expected_results.push_back(r);
	endfunction

	function void check_result(out_item_t got);
		out_item_t e;
		if (expected_results.size() == 0) begin
			$error("unexpected result kind=%0d", got.result_kind);
			errors++;
			return;
		end
		e = expected_results.pop_front();
		if (got.result_kind !== e.result_kind) begin
			$error("result_kind exp %0d got %0d", e.result_kind, got.result_kind);
			errors++;
		end
		if (got.text_byte !== e.text_byte) begin
			$error("text_byte exp %h got %h", e.text_byte, got.text_byte);
			errors++;
		end
		if (got.tag_name !== e.tag_name) begin
			$error("tag_name exp %h got %h", e.tag_name, got.tag_name);
			errors++;
		end
		if (got.tag_name_length !== e.tag_name_length) begin
			$error("tag_name_length exp %0d got %0d", e.tag_name_length,
				got.tag_name_length);
			errors++;
		end
		if (got.name_truncated !== e.name_truncated) begin
			$error("name_truncated exp %0d got %0d", e.name_truncated,
				got.name_truncated);
			errors++;
		end
		if (got.span_start !== e.span_start) begin
			$error("span_start exp %0d got %0d", e.span_start, got.span_start);
			errors++;
		end
		if (got.span_end !== e.span_end) begin
			$error("span_end exp %0d got %0d", e.span_end, got.span_end);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	in_item_t item;
	logic result_valid;
	logic result_ready;
	out_item_t result;
	span_scoreboard sb;
	int sent;
	int hold_off;

	markup_tag_span_extractor_top DUT (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item_ready(item_ready),
		.item(item), .result_valid(result_valid), .result_ready(result_ready),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		else if (p < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(input bit op, input logic [7:0] c);
		int g;
		g = gap_len();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		item.operation <= op;
		item.char_byte <= c;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		sb.note_input(item);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] c);
		send(1'b0, c);
	endtask

	task automatic send_str(input string s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	task automatic rand_name(input int n);
		logic [7:0] c;
		repeat (n) begin
			do
				c = 8'($urandom_range(0, 255));
			while (c == CH_OPEN || c == CH_CLOSE || c == CH_SLASH);
			send_byte(c);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	initial begin
		int g;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				result_ready <= 1'b0;
				hold_off--;
			end else begin
				g = gap_len();
				if (g > 0) begin
					result_ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
					@(negedge clk);
				end
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		int dep;
		int p;
		sb = new();
		sb.clear_state();
		sb.errors = 0;
		sent = 0;
		hold_off = 0;
		item_valid = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_str("ab<p>x");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_str("</p>>");
		send_str("</q>");
		send_str("<abcdefghij>t</abcdefghij>");
		send_str("<");
		send(1'b1, 8'hA5);
		send_str("<a<b>c</>");
		send(1'b1, 8'h00);
		hold_off = 200;
		repeat (34) send_str("<x>");
		send_str("</x>");
		send(1'b1, 8'h00);
		while (sent < 1550) begin
			p = $urandom_range(0, 99);
			if (p < 10) begin
				send(1'b1, 8'($urandom_range(0, 255)));
			end else if (p < 30) begin
				dep = $urandom_range(1, 4);
				repeat (dep) begin
					send_byte(CH_OPEN);
					rand_name($urandom_range(0, 11));
					send_byte(CH_CLOSE);
					rand_name($urandom_range(0, 3));
				end
				repeat (dep) begin
					send_str("</");
					rand_name($urandom_range(0, 9));
					send_byte(CH_CLOSE);
				end
			end else if (p < 35) begin
				send_str("<y>");
			end else if (p < 38) begin
				repeat (100) send_byte(8'h61);
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
		send(1'b1, 8'h00);
		item_valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

FILE: filelist.f
hdl/mte_pkg.sv
hdl/mte_front.sv
hdl/mte_queue.sv
hdl/mte_back.sv
hdl/markup_tag_span_extractor_top.sv
tb/sv/tb_top.sv
